// ===== hw/rtl/msst_pkg.sv =====
// shared constants, codes and the slot entry type of the software timer table
`default_nettype none

package msst_pkg;

  localparam int NumSlots   = 8;
  localparam int SlotIdxW   = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int MaxResults = 8;
  localparam int CntW       = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeAdd    = 2'd1,
    ModeCancel = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KindAdded     = 3'd0,
    KindFull      = 3'd1,
    KindCancelled = 3'd2,
    KindNotActive = 3'd3,
    KindFired     = 3'd4
  } kind_e;

  typedef struct packed {
    logic        rep;
    logic [15:0] elapsed;
    logic [15:0] period;
    logic [7:0]  code;
    logic [15:0] arg;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // low three bits of a slot number
  function automatic logic [2:0] slot_field(logic [SlotIdxW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msst_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module msst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/multi_slot_software_timer.sv =====
// top level of the multi-slot software timer table
//
// Keeps NumSlots timer slots; each beat on the slave side is a tick, an add or a
// cancel, chosen by tuser; a beat of the unused mode is taken and dropped. An add
// or a cancel is held in the request registers and shows its one result from the
// output register once that register is free. A tick walks the slots in ascending
// order through the single slot memory: an idle slot is only passed in the read
// state, an active one is read, then updated and written back, and a closing state
// ends the tick; the master side can stall the update and closing states. Fires
// come out in ascending slot order with tlast on the final one; a tick that fires
// nothing gives no beat. A new beat is taken only when the previous one is
// finished, while its last result may still wait in the output register. Slot
// data needs no reset; only the active bits are cleared.
`default_nettype none

module multi_slot_software_timer
  import msst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // period[15:0], repeat_req[16], task_code[24:17], task_arg[40:25], slot_select[43:41]
  input  wire logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot[2:0], fired_code[10:3], fired_arg[26:11]
  output logic [31:0]      m_axis_tdata,
  // kind[2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  typedef enum logic [2:0] {
    StIdle,
    StOp,
    StTickRd,
    StTickCalc,
    StTickEnd
  } state_e;

  state_e                state_q;
  logic [SlotIdxW-1:0]   idx_q;
  logic [NumSlots-1:0]   active_q;
  logic [CntW-1:0]       cnt_q;

  logic [1:0]            req_mode_q;
  logic [15:0]           req_period_q;
  logic                  req_rep_q;
  logic [7:0]            req_code_q;
  logic [15:0]           req_arg_q;
  logic [2:0]            req_sel_q;

  logic                  pend_valid_q;
  logic [2:0]            pend_slot_q;
  logic [7:0]            pend_code_q;
  logic [15:0]           pend_arg_q;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  logic [2:0]            out_slot_q;
  logic [7:0]            out_code_q;
  logic [15:0]           out_arg_q;
  logic                  out_last_q;

  logic                  ram_we;
  logic [SlotIdxW-1:0]   ram_waddr;
  entry_t                ram_wdata;
  logic                  ram_re;
  logic [EntryW-1:0]     ram_rdata;
  entry_t                rd;

  logic                  free_found;
  logic [SlotIdxW-1:0]   free_idx;
  logic [15:0]           elapsed_inc;
  logic                  fire;
  logic                  report;
  logic                  stall;
  logic                  out_free;
  logic [SlotIdxW-1:0]   sel_idx;
  logic                  sel_ok;
  logic                  last_idx;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_arg_q, out_code_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  assign rd          = entry_t'(ram_rdata);
  assign elapsed_inc = rd.elapsed + 16'd1;
  assign fire        = (elapsed_inc == rd.period);
  assign report      = fire && (cnt_q < CntW'(MaxResults));
  assign out_free    = !out_valid_q || m_axis_tready;
  assign stall       = report && pend_valid_q && !out_free;
  assign sel_idx     = SlotIdxW'(req_sel_q);
  assign sel_ok      = (32'(req_sel_q) < NumSlots) && active_q[sel_idx];
  assign last_idx    = (idx_q == SlotIdxW'(NumSlots - 1));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    ram_re    = (state_q == StTickRd) && active_q[idx_q];
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = rd;
    if (state_q == StOp && req_mode_q == ModeAdd && free_found && out_free) begin
      ram_we            = 1'b1;
      ram_waddr         = free_idx;
      ram_wdata.rep     = req_rep_q;
      ram_wdata.elapsed = '0;
      ram_wdata.period  = req_period_q;
      ram_wdata.code    = req_code_q;
      ram_wdata.arg     = req_arg_q;
    end else if (state_q == StTickCalc && !stall) begin
      ram_we            = 1'b1;
      ram_wdata.elapsed = (fire && rd.rep) ? 16'd0 : elapsed_inc;
    end
  end

  msst_ram #(
    .WIDTH(EntryW),
    .DEPTH(NumSlots)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= '0;
      active_q     <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            req_mode_q   <= s_axis_tuser;
            req_period_q <= s_axis_tdata[15:0];
            req_rep_q    <= s_axis_tdata[16];
            req_code_q   <= s_axis_tdata[24:17];
            req_arg_q    <= s_axis_tdata[40:25];
            req_sel_q    <= s_axis_tdata[43:41];
            case (s_axis_tuser)
              ModeTick: begin
                idx_q        <= '0;
                cnt_q        <= '0;
                pend_valid_q <= 1'b0;
                state_q      <= StTickRd;
              end
              ModeAdd, ModeCancel: begin
                state_q <= StOp;
              end
              default: begin
                state_q <= StIdle;
              end
            endcase
          end
        end
        StOp: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            out_code_q  <= '0;
            out_arg_q   <= '0;
            if (req_mode_q == ModeAdd) begin
              if (free_found) begin
                active_q[free_idx] <= 1'b1;
                out_kind_q         <= KindAdded;
                out_slot_q         <= slot_field(free_idx);
              end else begin
                out_kind_q <= KindFull;
                out_slot_q <= '0;
              end
            end else begin
              if (sel_ok) begin
                active_q[sel_idx] <= 1'b0;
                out_kind_q        <= KindCancelled;
              end else begin
                out_kind_q <= KindNotActive;
              end
              out_slot_q <= req_sel_q;
            end
            state_q <= StIdle;
          end
        end
        StTickRd: begin
          if (active_q[idx_q]) begin
            state_q <= StTickCalc;
          end else if (last_idx) begin
            state_q <= StTickEnd;
          end else begin
            idx_q <= idx_q + SlotIdxW'(1);
          end
        end
        StTickCalc: begin
          if (!stall) begin
            if (fire && !rd.rep) begin
              active_q[idx_q] <= 1'b0;
            end
            if (report) begin
              cnt_q        <= cnt_q + CntW'(1);
              pend_valid_q <= 1'b1;
              pend_slot_q  <= slot_field(idx_q);
              pend_code_q  <= rd.code;
              pend_arg_q   <= rd.arg;
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                out_kind_q  <= KindFired;
                out_slot_q  <= pend_slot_q;
                out_code_q  <= pend_code_q;
                out_arg_q   <= pend_arg_q;
                out_last_q  <= 1'b0;
              end
            end
            if (last_idx) begin
              state_q <= StTickEnd;
            end else begin
              idx_q   <= idx_q + SlotIdxW'(1);
              state_q <= StTickRd;
            end
          end
        end
        StTickEnd: begin
          if (!pend_valid_q) begin
            state_q <= StIdle;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_kind_q   <= KindFired;
            out_slot_q   <= pend_slot_q;
            out_code_q   <= pend_code_q;
            out_arg_q    <= pend_arg_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msst_chk.sv =====
// port checker for the software timer table and its bind
`default_nettype none

module msst_chk
  import msst_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // add and cancel answers are single beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KindFired |-> m_axis_tlast)
    else $error("non-fire result without tlast");

  // tags only travel with fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KindFired |-> m_axis_tdata[26:3] == 24'd0)
    else $error("non-fire result carries tags");

  // a full table reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindFull |-> m_axis_tdata[2:0] == 3'd0)
    else $error("table full result with nonzero slot");

  // a tick, add or cancel beat blocks the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready
      && (s_axis_tuser == ModeTick || s_axis_tuser == ModeAdd
          || s_axis_tuser == ModeCancel)
    |=> !s_axis_tready)
    else $error("slave handshake sequence broken");

endmodule

bind multi_slot_software_timer msst_chk u_msst_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

// ===== verif/timer_table_checker.sv =====
// checker for the software timer table: predicts every result beat and compares it
module timer_table_checker
  import msst_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  // period[15:0], repeat_req[16], task_code[24:17], task_arg[40:25], slot_select[43:41]
  input  wire logic [47:0] s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot[2:0], fired_code[10:3], fired_arg[26:11]
  input  wire logic [31:0] m_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               err_count_o,
  output int               pending_o
);

  typedef struct {
    kind_e       kind;
    logic [2:0]  slot;
    logic [7:0]  code;
    logic [15:0] arg;
    logic        last;
  } timer_event_t;

  logic        armed    [NumSlots];
  logic        rearm    [NumSlots];
  logic [15:0] elapsed  [NumSlots];
  logic [15:0] period   [NumSlots];
  logic [7:0]  tag_code [NumSlots];
  logic [15:0] tag_arg  [NumSlots];

  timer_event_t due_events[$];
  int errors = 0;

  assign err_count_o = errors;

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void advance_table(logic [1:0] mode, logic [47:0] d);
    logic [15:0]  per;
    logic         rep;
    logic [7:0]   code;
    logic [15:0]  arg;
    logic [2:0]   sel;
    int           n;
    int           free_idx;
    timer_event_t ev;
    per  = d[15:0];
    rep  = d[16];
    code = d[24:17];
    arg  = d[40:25];
    sel  = d[43:41];
    n = 0;
    free_idx = -1;
    case (mode)
      ModeTick: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (armed[i]) begin
            elapsed[i] = elapsed[i] + 16'd1;
            if (elapsed[i] == period[i]) begin
              if (rearm[i]) elapsed[i] = '0;
              else armed[i] = 1'b0;
              if (n < MaxResults) begin
                ev = '{KindFired, 3'(i), tag_code[i], tag_arg[i], 1'b0};
                due_events.push_back(ev);
                n++;
              end
            end
          end
        end
        if (n > 0) begin
          ev = due_events.pop_back();
          ev.last = 1'b1;
          due_events.push_back(ev);
        end
      end
      ModeAdd: begin
        for (int i = NumSlots - 1; i >= 0; i--) begin
          if (!armed[i]) free_idx = i;
        end
        if (free_idx >= 0) begin
          armed[free_idx]    = 1'b1;
          rearm[free_idx]    = rep;
          elapsed[free_idx]  = '0;
          period[free_idx]   = per;
          tag_code[free_idx] = code;
          tag_arg[free_idx]  = arg;
          ev = '{KindAdded, 3'(free_idx), 8'd0, 16'd0, 1'b1};
        end else begin
          ev = '{KindFull, 3'd0, 8'd0, 16'd0, 1'b1};
        end
        due_events.push_back(ev);
      end
      ModeCancel: begin
        if (int'(sel) < NumSlots && armed[sel]) begin
          armed[sel] = 1'b0;
          ev = '{KindCancelled, sel, 8'd0, 16'd0, 1'b1};
        end else begin
          ev = '{KindNotActive, sel, 8'd0, 16'd0, 1'b1};
        end
        due_events.push_back(ev);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_event_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) armed[i] = 1'b0;
      due_events.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d slot %0d",
                                    m_axis_tuser, m_axis_tdata[2:0]));
        end else begin
          want = due_events.pop_front();
          if (m_axis_tuser !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", m_axis_tuser, want.kind));
          if (m_axis_tdata[2:0] !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", m_axis_tdata[2:0], want.slot));
          if (m_axis_tdata[10:3] !== want.code)
            report_mismatch($sformatf("fired_code got %0h want %0h",
                                      m_axis_tdata[10:3], want.code));
          if (m_axis_tdata[26:11] !== want.arg)
            report_mismatch($sformatf("fired_arg got %0h want %0h",
                                      m_axis_tdata[26:11], want.arg));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("tlast got %0b want %0b", m_axis_tlast, want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_table(s_axis_tuser, s_axis_tdata);
      pending_o = due_events.size();
    end
  end

endmodule

// ===== verif/tb_multi_slot_software_timer.sv =====
// testbench top for the timer table: drives ticks, adds, cancels and unused modes, gives the verdict
module tb_multi_slot_software_timer;
  import msst_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int StallLimit  = 4000;
  localparam int HoldCycles  = 300;
  localparam int RandomItems = 140;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int errors;
  int pending;
  int idle_cycles = 0;
  bit gaps_on;
  bit hold_req;
  bit hold_done;

  always #4 clk = ~clk;

  multi_slot_software_timer DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  timer_table_checker u_table_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_count_o   (errors),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] mode, logic [15:0] per, logic rep, logic [7:0] code,
                           logic [15:0] arg, logic [2:0] sel);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, sel, arg, code, rep, per};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_beat(ModeTick, 16'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
              3'($urandom));
  endtask

  task automatic send_add(logic [15:0] per, logic rep, logic [7:0] code, logic [15:0] arg);
    send_beat(ModeAdd, per, rep, code, arg, 3'($urandom));
  endtask

  task automatic send_cancel(logic [2:0] sel);
    send_beat(ModeCancel, 16'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), sel);
  endtask

  initial begin : drain
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n_sent;
    int pick;
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ModeTick;
    gaps_on       = 1'b1;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_add(16'd1, 1'b0, 8'hFF, 16'hFFFF);
    send_add(16'hFFFF, 1'b1, 8'h00, 16'h0000);
    send_add(16'd2, 1'b1, 8'hA5, 16'h5A5A);
    send_tick();
    send_tick();
    send_beat(ModeUnused, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF, 3'd7);
    send_cancel(3'd1);
    send_cancel(3'd1);
    send_cancel(3'd7);
    send_cancel(3'd2);

    // fill the table, overflow it, then fire every slot in one tick
    for (int i = 0; i < NumSlots; i++)
      send_add(16'd1, 1'(i), 8'(i * 37 + 1), ~16'(i * 4099));
    send_add(16'd3, 1'b1, 8'h5A, 16'h1234);
    send_tick();
    send_tick();
    for (int i = 1; i < NumSlots; i += 2) send_cancel(3'(i));

    // a period of zero never fires in the random run, though a random cancel may still free its slot
    gaps_on = 1'b0;
    send_add(16'd0, 1'b0, 8'h3C, 16'hC3C3);

    n_sent = 0;
    while (n_sent < RandomItems) begin
      if (n_sent == 20) hold_req = 1'b1;
      if (n_sent % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        send_tick();
        n_sent++;
      end else if (pick < 78) begin
        if ($urandom_range(0, 7) == 0)
          send_add(16'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
        else
          send_add(16'($urandom_range(1, 6)), 1'($urandom), 8'($urandom), 16'($urandom));
        n_sent++;
      end else if (pick < 95) begin
        send_cancel(3'($urandom_range(0, 7)));
        n_sent++;
      end else begin
        send_beat(ModeUnused, 16'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
                  3'($urandom));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/msst_pkg.sv
hw/rtl/msst_ram.sv
hw/rtl/multi_slot_software_timer.sv
hw/rtl/msst_chk.sv
verif/timer_table_checker.sv
verif/tb_multi_slot_software_timer.sv
